### rtl/drc_pkg.sv
package drc_pkg;

  localparam int MaxClusters = 16;
  localparam int CoordBits   = 12;
  localparam int LimitBits   = 5;
  localparam logic [LimitBits-1:0] LimitReset = 5'd16;

  typedef struct packed {
    logic                 mode;
    logic [CoordBits-1:0] rect_x;
    logic [CoordBits-1:0] rect_y;
    logic [CoordBits:0]   rect_width;
    logic [CoordBits:0]   rect_height;
  } drc_in_t;

  typedef struct packed {
    logic                 valid_res;
    logic [CoordBits-1:0] out_left;
    logic [CoordBits-1:0] out_top;
    logic [CoordBits-1:0] out_right;
    logic [CoordBits-1:0] out_bottom;
    logic                 last;
  } drc_out_t;

  localparam logic MODE_ADD   = 1'b0;
  localparam logic MODE_DRAIN = 1'b1;

endpackage

### rtl/drc_store.sv
// Cluster store: one write port, one registered read port.
module drc_store #(
  parameter int Depth = 16,
  parameter int Cw    = 12
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [4*Cw-1:0]          wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [4*Cw-1:0]          rdata
);
  logic [4*Cw-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### rtl/drc_area.sv
// Area of an inclusive box, registered (one multiplier).
module drc_area #(
  parameter int Cw = 12
) (
  input  logic              clk,
  input  logic [Cw-1:0]     l,
  input  logic [Cw-1:0]     t,
  input  logic [Cw-1:0]     r,
  input  logic [Cw-1:0]     b,
  output logic [2*Cw+1:0]   area
);
  logic [Cw:0] w;
  logic [Cw:0] h;

  assign w = {1'b0, r} - {1'b0, l} + (Cw+1)'(1);
  assign h = {1'b0, b} - {1'b0, t} + (Cw+1)'(1);

  always_ff @(posedge clk) begin
    area <= w * h;
  end
endmodule

### rtl/dirty_rect_clusterizer_top.sv
// Dirty-rectangle clusterizer. Each add item folds a rectangle into up to
// cluster_limit disjoint clusters kept in a single-port-read memory; a drain
// item streams all clusters in slot order (last marks the final one, an
// empty store gives one item with valid_res 0) and clears them. All work
// is a sequencer over the memory, one read per cycle. Each add runs a
// containment scan and then a neighbor search; when no neighbor qualifies
// and the store holds cluster_limit clusters, a join search and (with two
// or more clusters held) a pair search follow before the commit. A drain
// reads and emits each cluster in turn, waiting while the output stalls.
// One item is worked on at a time.
module dirty_rect_clusterizer_top
  import drc_pkg::*;
#(
  parameter int MAX_CLUSTERS = MaxClusters
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  drc_in_t        in_item,
  output logic           out_valid,
  input  logic           out_stall,
  output drc_out_t       out_item,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [LimitBits-1:0] cfg_data
);
  localparam int Aw = $clog2(MAX_CLUSTERS);
  localparam int Nw = $clog2(MAX_CLUSTERS + 1);
  localparam int Cw = CoordBits;
  localparam int Ew = 2*Cw + 2;
  localparam logic [Cw-1:0] CMAX = {Cw{1'b1}};

  // states
  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_INS_RD = 5'd1;   // containment scan
  localparam logic [4:0] S_INS_CK = 5'd2;
  localparam logic [4:0] S_J_RD   = 5'd3;   // candidate i read
  localparam logic [4:0] S_J_A1   = 5'd4;   // area of cluster
  localparam logic [4:0] S_J_A2   = 5'd5;   // area of union
  localparam logic [4:0] S_J_A3   = 5'd6;
  localparam logic [4:0] S_CL_RD  = 5'd7;   // overlap check scan
  localparam logic [4:0] S_CL_CK  = 5'd8;
  localparam logic [4:0] S_J_NX   = 5'd9;
  localparam logic [4:0] S_P_RDI  = 5'd10;  // pair search
  localparam logic [4:0] S_P_RDJ  = 5'd11;
  localparam logic [4:0] S_P_A1   = 5'd12;
  localparam logic [4:0] S_P_A2   = 5'd13;
  localparam logic [4:0] S_P_A3   = 5'd14;
  localparam logic [4:0] S_P_A4   = 5'd15;
  localparam logic [4:0] S_P_NX   = 5'd16;
  localparam logic [4:0] S_WR     = 5'd17;  // commit
  localparam logic [4:0] S_M_RD1  = 5'd18;
  localparam logic [4:0] S_M_RD2  = 5'd19;
  localparam logic [4:0] S_M_W1   = 5'd20;
  localparam logic [4:0] S_M_W2   = 5'd21;
  localparam logic [4:0] S_DR_RD  = 5'd22;
  localparam logic [4:0] S_DR_OUT = 5'd23;
  localparam logic [4:0] S_DR_E   = 5'd24;
  localparam logic [4:0] S_J_RDW  = 5'd25;
  localparam logic [4:0] S_P_RDW  = 5'd26;
  localparam logic [4:0] S_M_W3   = 5'd27;

  // phase of the join scan
  localparam logic [1:0] PH_NEIGH = 2'd0;
  localparam logic [1:0] PH_FULL  = 2'd1;
  localparam logic [1:0] PH_PAIR  = 2'd2;

  logic [4:0] state;
  logic [1:0] phase;
  logic [LimitBits-1:0] limit;
  logic [Nw-1:0] count;
  logic [Nw-1:0] idx_i;
  logic [Nw-1:0] idx_j;
  logic [Nw-1:0] idx_c;
  logic [Cw-1:0] rl, rt, rr, rb;       // incoming rectangle
  logic [Cw-1:0] al, at, ar, ab;       // cluster i
  logic [Cw-1:0] bl, bt, br, bb;       // cluster j
  logic [Cw-1:0] ul, ut, ur, ub;       // candidate union
  logic [Ew-1:0] area_a;
  logic [Ew-1:0] area_b;
  logic signed [Ew:0] cost;
  logic signed [Ew:0] best;
  logic          best_ok;
  logic signed [Ew:0] fb_cost;
  logic          fb_ok;
  logic [Aw-1:0] pick, fb, m1, m2;
  logic          pick_ok, m_ok;
  logic          clear;

  // memory ports
  logic          we;
  logic [Aw-1:0] waddr;
  logic [4*Cw-1:0] wdata;
  logic [Aw-1:0] raddr;
  logic [4*Cw-1:0] rdata;
  logic [Cw-1:0] dl, dt, dr, db;

  drc_store #(.Depth(MAX_CLUSTERS), .Cw(Cw)) u_store (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );
  assign {dl, dt, dr, db} = rdata;

  // shared area unit
  logic [Cw-1:0] ml, mt, mr, mb;
  logic [Ew-1:0] area_q;
  drc_area #(.Cw(Cw)) u_area (
    .clk(clk), .l(ml), .t(mt), .r(mr), .b(mb), .area(area_q)
  );

  // growth costs; a pair of overlapping clusters can cost less than zero
  logic signed [Ew:0] join_cost;
  logic signed [Ew:0] pair_cost;
  assign join_cost = $signed({1'b0, area_q}) - $signed({1'b0, area_a});
  assign pair_cost = join_cost - $signed({1'b0, area_b});

  // effective limit, clamped
  logic [Nw:0] cap;
  always_comb begin
    if (limit == '0) cap = (Nw+1)'(1);
    else if ({{(Nw+1){1'b0}}, limit} > (Nw+LimitBits+1)'(MAX_CLUSTERS))
      cap = (Nw+1)'(MAX_CLUSTERS);
    else cap = (Nw+1)'(limit);
  end

  // incoming rectangle conversion
  logic [Cw:0] w_eff, h_eff;
  logic [Cw+13:0] r_full, b_full;
  always_comb begin
    w_eff = (in_item.rect_width  == '0) ? (Cw+1)'(1) : in_item.rect_width;
    h_eff = (in_item.rect_height == '0) ? (Cw+1)'(1) : in_item.rect_height;
    r_full = (Cw+14)'(in_item.rect_x[Cw-1:0]) + (Cw+14)'(w_eff) - (Cw+14)'(1);
    b_full = (Cw+14)'(in_item.rect_y[Cw-1:0]) + (Cw+14)'(h_eff) - (Cw+14)'(1);
  end

  // geometry helpers on current read data
  logic d_meets_u;
  logic d_holds_r;
  logic d_meets_big;
  logic [Cw+1:0] gl, gt, gr, gb;
  always_comb begin
    gl = {2'b0, rl} - (Cw+2)'(1);
    gt = {2'b0, rt} - (Cw+2)'(1);
    gr = {2'b0, rr} + (Cw+2)'(2);
    gb = {2'b0, rb} + (Cw+2)'(2);
    d_meets_u = (dl <= ur) && (ul <= dr) && (dt <= ub) && (ut <= db);
    d_holds_r = (rl >= dl) && (rr <= dr) && (rt >= dt) && (rb <= db);
    // grown box may reach -1: treat as signed compare
    d_meets_big = ($signed({2'b0, dl}) <= $signed(gr)) &&
                  ($signed(gl) <= $signed({2'b0, dr})) &&
                  ($signed({2'b0, dt}) <= $signed(gb)) &&
                  ($signed(gt) <= $signed({2'b0, db}));
  end

  // read address and area operand select
  always_comb begin
    raddr = idx_i[Aw-1:0];
    unique case (state)
      S_CL_RD, S_CL_CK: raddr = idx_c[Aw-1:0];
      S_P_RDJ, S_P_RDW: raddr = idx_j[Aw-1:0];
      S_M_RD2:          raddr = m2;
      S_M_W1:           raddr = Aw'(count - Nw'(1));
      default:          raddr = idx_i[Aw-1:0];
    endcase
  end

  always_comb begin
    {ml, mt, mr, mb} = {ul, ut, ur, ub};
    case (state)
      S_J_A1, S_P_A1: {ml, mt, mr, mb} = {al, at, ar, ab};
      S_P_A2:         {ml, mt, mr, mb} = {bl, bt, br, bb};
      default:        {ml, mt, mr, mb} = {ul, ut, ur, ub};
    endcase
  end

  logic [Nw-1:0] n_scan;   // number of candidates scanned in the pair loop
  assign n_scan = count;

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      limit     <= LimitReset;
      count     <= '0;
      out_valid <= 1'b0;
      we        <= 1'b0;
    end else begin
      we <= 1'b0;
      if (cfg_valid && cfg_ready) limit <= cfg_data;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (in_item.mode == MODE_DRAIN) begin
              idx_i <= '0;
              state <= (count == '0) ? S_DR_E : S_DR_RD;
            end else begin
              rl <= in_item.rect_x[Cw-1:0];
              rt <= in_item.rect_y[Cw-1:0];
              rr <= (r_full > (Cw+14)'(CMAX)) ? CMAX : r_full[Cw-1:0];
              rb <= (b_full > (Cw+14)'(CMAX)) ? CMAX : b_full[Cw-1:0];
              idx_i   <= '0;
              pick_ok <= 1'b0;
              best_ok <= 1'b0;
              fb_ok   <= 1'b0;
              m_ok    <= 1'b0;
              phase   <= PH_NEIGH;
              state   <= (count == '0) ? S_WR : S_INS_RD;
            end
          end
        end
        // containment
        S_INS_RD: state <= S_INS_CK;
        S_INS_CK: begin
          if (d_holds_r) state <= S_IDLE;
          else if (idx_i + Nw'(1) == count) begin
            idx_i <= '0;
            state <= S_J_RD;
          end else begin
            idx_i <= idx_i + Nw'(1);
            state <= S_INS_RD;
          end
        end
        // join candidate
        S_J_RD: state <= S_J_RDW;
        S_J_RDW: begin
          {al, at, ar, ab} <= rdata;
          ul <= (dl < rl) ? dl : rl;
          ut <= (dt < rt) ? dt : rt;
          ur <= (dr > rr) ? dr : rr;
          ub <= (db > rb) ? db : rb;
          if (phase == PH_NEIGH && !d_meets_big) state <= S_J_NX;
          else state <= S_J_A1;
        end
        S_J_A1: state <= S_J_A2;
        S_J_A2: begin
          area_a <= area_q;
          state  <= S_J_A3;
        end
        S_J_A3: begin
          cost <= join_cost;
          if (phase == PH_FULL && (!fb_ok || join_cost < fb_cost)) begin
            fb_ok   <= 1'b1;
            fb_cost <= join_cost;
            fb      <= idx_i[Aw-1:0];
          end
          if (best_ok && join_cost >= best) state <= S_J_NX;
          else begin
            idx_c <= '0;
            clear <= 1'b1;
            state <= S_CL_RD;
          end
        end
        // overlap scan of union against others
        S_CL_RD: state <= S_CL_CK;
        S_CL_CK: begin
          logic hit;
          hit = d_meets_u && (idx_c != idx_i) &&
                !(phase == PH_PAIR && idx_c == idx_j);
          if (hit || idx_c + Nw'(1) == count) begin
            if (!hit && clear) begin
              best    <= cost;
              best_ok <= 1'b1;
              if (phase == PH_PAIR) begin
                m_ok <= 1'b1;
                m1   <= idx_i[Aw-1:0];
                m2   <= idx_j[Aw-1:0];
              end else begin
                pick_ok <= 1'b1;
                pick    <= idx_i[Aw-1:0];
              end
            end
            state <= (phase == PH_PAIR) ? S_P_NX : S_J_NX;
          end else begin
            idx_c <= idx_c + Nw'(1);
            state <= S_CL_RD;
          end
        end
        S_J_NX: begin
          if (idx_i + Nw'(1) != count) begin
            idx_i <= idx_i + Nw'(1);
            state <= S_J_RD;
          end else if (phase == PH_NEIGH) begin
            if (pick_ok) state <= S_WR;
            else if ({1'b0, count} < cap) state <= S_WR;
            else begin
              phase   <= PH_FULL;
              idx_i   <= '0;
              best_ok <= 1'b0;
              state   <= S_J_RD;
            end
          end else if (count == Nw'(1)) begin
            // a single cluster has no pair to merge
            state <= S_WR;
          end else begin
            phase <= PH_PAIR;
            idx_i <= '0;
            idx_j <= Nw'(1);
            state <= S_P_RDI;
          end
        end
        // pair search
        S_P_RDI: state <= S_P_RDJ;
        S_P_RDJ: begin
          {al, at, ar, ab} <= rdata;
          state <= S_P_RDW;
        end
        S_P_RDW: begin
          {bl, bt, br, bb} <= rdata;
          ul <= (dl < al) ? dl : al;
          ut <= (dt < at) ? dt : at;
          ur <= (dr > ar) ? dr : ar;
          ub <= (db > ab) ? db : ab;
          state <= S_P_A1;
        end
        S_P_A1: state <= S_P_A2;
        S_P_A2: begin
          area_a <= area_q;
          state  <= S_P_A3;
        end
        S_P_A3: begin
          area_b <= area_q;
          state  <= S_P_A4;
        end
        S_P_A4: begin
          cost <= pair_cost;
          if (best_ok && pair_cost >= best)
            state <= S_P_NX;
          else begin
            idx_c <= '0;
            clear <= 1'b1;
            state <= S_CL_RD;
          end
        end
        S_P_NX: begin
          logic [Nw-1:0] ni, nj;
          ni = idx_i;
          nj = idx_j + Nw'(1);
          if (nj == ni) nj = nj + Nw'(1);
          if (nj >= n_scan) begin
            ni = idx_i + Nw'(1);
            nj = (ni == '0) ? Nw'(1) : '0;
          end
          if (ni >= n_scan) state <= S_WR;
          else begin
            idx_i <= ni;
            idx_j <= nj;
            state <= S_P_RDI;
          end
        end
        // commit
        S_WR: begin
          if (m_ok) begin
            idx_i <= Nw'(m1);
            state <= S_M_RD1;
          end else if (pick_ok || fb_ok) begin
            idx_i <= Nw'(pick_ok ? pick : fb);
            state <= S_M_RD1;
            phase <= PH_NEIGH;
          end else begin
            we    <= 1'b1;
            waddr <= count[Aw-1:0];
            wdata <= {rl, rt, rr, rb};
            count <= count + Nw'(1);
            state <= S_IDLE;
          end
        end
        S_M_RD1: state <= S_M_RD2;
        S_M_RD2: begin
          // rdata = slot idx_i
          if (!m_ok) begin
            we    <= 1'b1;
            waddr <= idx_i[Aw-1:0];
            wdata <= {((dl < rl) ? dl : rl), ((dt < rt) ? dt : rt),
                      ((dr > rr) ? dr : rr), ((db > rb) ? db : rb)};
            state <= S_IDLE;
          end else begin
            {al, at, ar, ab} <= rdata;
            state <= S_M_W1;
          end
        end
        S_M_W1: begin
          // rdata = slot m2
          we    <= 1'b1;
          waddr <= m1;
          wdata <= {((dl < al) ? dl : al), ((dt < at) ? dt : at),
                    ((dr > ar) ? dr : ar), ((db > ab) ? db : ab)};
          state <= S_M_W2;
        end
        S_M_W2: begin
          // rdata = last slot, read before the m1 write landed; forward the
          // merged box when m1 is the last slot
          we    <= 1'b1;
          waddr <= m2;
          if (m1 == Aw'(count - Nw'(1)))
            wdata <= wdata;
          else
            wdata <= rdata;
          state <= S_M_W3;
        end
        S_M_W3: begin
          // new rectangle into the last slot
          we    <= 1'b1;
          waddr <= Aw'(count - Nw'(1));
          wdata <= {rl, rt, rr, rb};
          state <= S_IDLE;
        end
        // drain
        S_DR_RD: begin
          if (!out_valid || !out_stall) state <= S_DR_OUT;
        end
        S_DR_OUT: begin
          out_valid          <= 1'b1;
          out_item.valid_res <= 1'b1;
          out_item.out_left  <= dl;
          out_item.out_top   <= dt;
          out_item.out_right <= dr;
          out_item.out_bottom <= db;
          out_item.last      <= (idx_i + Nw'(1) == count);
          if (idx_i + Nw'(1) == count) begin
            count <= '0;
            state <= S_IDLE;
          end else begin
            idx_i <= idx_i + Nw'(1);
            state <= S_DR_RD;
          end
        end
        S_DR_E: begin
          if (!out_valid || !out_stall) begin
            out_valid           <= 1'b1;
            out_item.valid_res  <= 1'b0;
            out_item.out_left   <= '0;
            out_item.out_top    <= '0;
            out_item.out_right  <= '0;
            out_item.out_bottom <= '0;
            out_item.last       <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (out_valid && !out_stall && state != S_DR_OUT && state != S_DR_E)
        out_valid <= 1'b0;
    end
  end

  // store holds no more clusters than its depth
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= Nw'(MAX_CLUSTERS))
    else $error("cluster count overflow");

  // a drain leaves the store empty
  a_drain_clears: assert property (@(posedge clk) disable iff (rst)
    (state == S_DR_OUT && out_item.last == 1'b0 && idx_i + Nw'(1) == count)
      |=> count == '0)
    else $error("drain did not clear");

  // input is only taken when idle
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |-> state == S_IDLE)
    else $error("accept while busy");
endmodule
